// ----- hw/rtl/iac_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iac_pkg
// shared types, codes and helpers for the ipv4 cidr allowlist check
// ----------------------------------------------------------------------------
package iac_pkg;

   localparam int unsigned MAX_ENTRIES = 16;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_CHAR  = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [8:0]  OCTET_SAT    = 9'd256;
   localparam logic [12:0] OCTET_LIMIT  = 13'd255;
   localparam logic [2:0]  OCTETS_LAST  = 3'd3;
   localparam logic [5:0]  PREFIX_FULL  = 6'd32;

   typedef struct packed {
      logic        ok;
      logic [31:0] address;
   } query_type;

   typedef struct packed {
      logic        valid;
      logic        hit;
      logic        ok;
      logic [31:0] address;
   } token_type;

   // prefix 0 gives no bits, 32 gives all bits
   function automatic logic [31:0] prefix_mask(input logic [5:0] prefix);
      prefix_mask = ~(32'hFFFF_FFFF >> prefix);
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/iac_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iac_req_if
// request channel: table writes, address characters and end of address
// ----------------------------------------------------------------------------
interface iac_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [3:0]  entry_index;
   logic [31:0] entry_network;
   logic [5:0]  entry_prefix;
   logic        entry_well_formed;
   logic [7:0]  char_code;

   modport source (
      output valid, operation, entry_index, entry_network, entry_prefix,
             entry_well_formed, char_code,
      input  ready
   );
   modport sink (
      input  valid, operation, entry_index, entry_network, entry_prefix,
             entry_well_formed, char_code,
      output ready
   );
endinterface
`default_nettype wire

// ----- hw/rtl/iac_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iac_rsp_if
// response channel: allow decision and address syntax flag
// ----------------------------------------------------------------------------
interface iac_rsp_if;
   logic valid;
   logic ready;
   logic allowed;
   logic address_ok;

   modport source (output valid, allowed, address_ok, input ready);
   modport sink   (input valid, allowed, address_ok, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/iac_parse.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iac_parse
// strict dotted-decimal parser, one character per cycle
// ----------------------------------------------------------------------------
module iac_parse (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             char_en,
   input  wire logic             end_en,
   input  wire logic [7:0]       char_code,
   output iac_pkg::query_type    query
);

   logic [8:0]  octet_ff, octet_in;
   logic [2:0]  done_ff, done_in;
   logic        digit_ff, digit_in;
   logic        bad_ff, bad_in;
   logic [31:0] addr_ff, addr_in;

   logic [12:0] octet_next;
   logic        close_fail;
   logic        is_digit;

   assign is_digit   = (char_code >= iac_pkg::CHAR_ZERO) && (char_code <= iac_pkg::CHAR_NINE);
   assign octet_next = 13'(octet_ff) * 13'd10 + 13'(char_code - iac_pkg::CHAR_ZERO);
   assign close_fail = !digit_ff || (octet_ff > 9'(iac_pkg::OCTET_LIMIT))
                       || (done_ff > iac_pkg::OCTETS_LAST);

   // end of address closes the last octet on the fly
   assign query.ok      = !bad_ff && !close_fail && (done_ff == iac_pkg::OCTETS_LAST);
   assign query.address = {addr_ff[23:0], octet_ff[7:0]};

   always_comb begin
      octet_in = octet_ff;
      done_in  = done_ff;
      digit_in = digit_ff;
      bad_in   = bad_ff;
      addr_in  = addr_ff;
      if (end_en) begin
         octet_in = '0;
         done_in  = '0;
         digit_in = 1'b0;
         bad_in   = 1'b0;
         addr_in  = '0;
      end else if (char_en && !bad_ff) begin
         if (char_code == iac_pkg::CHAR_DOT) begin
            if (close_fail) begin
               bad_in = 1'b1;
            end else begin
               addr_in  = {addr_ff[23:0], octet_ff[7:0]};
               done_in  = done_ff + 3'd1;
               octet_in = '0;
               digit_in = 1'b0;
            end
         end else if (is_digit) begin
            octet_in = (octet_next > iac_pkg::OCTET_LIMIT) ? iac_pkg::OCTET_SAT
                                                           : octet_next[8:0];
            digit_in = 1'b1;
         end else begin
            bad_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         octet_ff <= '0;
         done_ff  <= '0;
         digit_ff <= 1'b0;
         bad_ff   <= 1'b0;
         addr_ff  <= '0;
      end else begin
         octet_ff <= octet_in;
         done_ff  <= done_in;
         digit_ff <= digit_in;
         bad_ff   <= bad_in;
         addr_ff  <= addr_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/iac_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// iac_cell
// one allowlist entry; checks the passing query token and hands it on
// ----------------------------------------------------------------------------
module iac_cell #(
   parameter int unsigned CELL_INDEX = 0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                write_en,
   input  wire logic [3:0]          entry_index,
   input  wire logic [31:0]         entry_network,
   input  wire logic [5:0]          entry_prefix,
   input  wire logic                entry_well_formed,
   input  wire logic [4:0]          entry_count,
   input  wire iac_pkg::token_type  token_prev,
   output iac_pkg::token_type       token_next
);

   logic [31:0] network_ff;
   logic [5:0]  prefix_ff;
   logic        good_ff;

   iac_pkg::token_type token_ff, token_in;

   logic [31:0] mask;
   logic        in_use;
   logic        match;

   assign mask   = iac_pkg::prefix_mask(prefix_ff);
   assign in_use = CELL_INDEX < 32'(entry_count);
   assign match  = token_prev.ok && in_use && good_ff && (prefix_ff <= iac_pkg::PREFIX_FULL)
                   && ((token_prev.address & mask) == (network_ff & mask));

   always_comb begin
      token_in     = token_prev;
      token_in.hit = token_prev.hit || match;
   end

   always_ff @(posedge clock) begin
      if (write_en && (32'(entry_index) == CELL_INDEX)) begin
         network_ff <= entry_network;
         prefix_ff  <= entry_prefix;
         good_ff    <= entry_well_formed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= '0;
      end else if (advance) begin
         token_ff <= token_in;
      end
   end

   assign token_next = token_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/ipv4_text_cidr_allowlist_check.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_text_cidr_allowlist_check
// parses a dotted-decimal client address and checks it against a cidr table
// ----------------------------------------------------------------------------
//  channel    dir   handshake      word
//  req_chan   in    valid/ready    operation, entry fields, char_code
//  rsp_chan   out   valid/ready    allowed, address_ok
//  csr_*      in    write enable   entry_count
//
//  table writes and address characters take effect on acceptance
//  an end of address walks a token through MAX_ENTRIES cells, one per cycle
//  while the chain advances; its word is registered after the last cell
//  req_chan is held off while a token is in the chain; a stalled rsp_chan
//  freezes the chain at its last cell
//  synchronous active-high reset clears parse state and entry_count; table
//  entries hold garbage until written
// ----------------------------------------------------------------------------
module ipv4_text_cidr_allowlist_check #(
   parameter int unsigned MAX_ENTRIES = iac_pkg::MAX_ENTRIES
) (
   input  wire logic       clock,
   input  wire logic       reset,
   iac_req_if.sink         req_chan,
   iac_rsp_if.source       rsp_chan,
   input  wire logic       csr_write_enable,
   input  wire logic [4:0] csr_write_data
);

   logic [4:0] count_ff, count_in;
   logic       busy_ff, busy_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_allowed_ff, rsp_allowed_in;
   logic       rsp_ok_ff, rsp_ok_in;

   logic accept, write_en, char_en, end_en, advance, unload;

   iac_pkg::query_type query;
   iac_pkg::token_type chain [0:MAX_ENTRIES];

   assign req_chan.ready = !busy_ff;
   assign accept   = req_chan.valid && req_chan.ready;
   assign write_en = accept && (req_chan.operation == iac_pkg::OP_WRITE);
   assign char_en  = accept && (req_chan.operation == iac_pkg::OP_CHAR);
   assign end_en   = accept && (req_chan.operation == iac_pkg::OP_END);

   assign advance = !(chain[MAX_ENTRIES].valid && rsp_valid_ff && !rsp_chan.ready);
   assign unload  = chain[MAX_ENTRIES].valid && advance;

   iac_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .char_en   (char_en),
      .end_en    (end_en),
      .char_code (req_chan.char_code),
      .query     (query)
   );

   // empty table allows everything
   always_comb begin
      chain[0].valid   = end_en;
      chain[0].hit     = (count_ff == 5'd0);
      chain[0].ok      = query.ok;
      chain[0].address = query.address;
   end

   for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      iac_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock             (clock),
         .reset             (reset),
         .advance           (advance),
         .write_en          (write_en),
         .entry_index       (req_chan.entry_index),
         .entry_network     (req_chan.entry_network),
         .entry_prefix      (req_chan.entry_prefix),
         .entry_well_formed (req_chan.entry_well_formed),
         .entry_count       (count_ff),
         .token_prev        (chain[k]),
         .token_next        (chain[k+1])
      );
   end

   always_comb begin
      count_in       = csr_write_enable ? csr_write_data : count_ff;
      busy_in        = busy_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_allowed_in = rsp_allowed_ff;
      rsp_ok_in      = rsp_ok_ff;
      if (end_en) begin
         busy_in = 1'b1;
      end
      if (unload) begin
         busy_in        = 1'b0;
         rsp_valid_in   = 1'b1;
         rsp_allowed_in = chain[MAX_ENTRIES].hit;
         rsp_ok_in      = chain[MAX_ENTRIES].ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_allowed_ff <= rsp_allowed_in;
      rsp_ok_ff      <= rsp_ok_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.allowed    = rsp_allowed_ff;
   assign rsp_chan.address_ok = rsp_ok_ff;

endmodule
`default_nettype wire
